>>> hdl/wildcard_pattern_search_assert.svh
// Assertion macros for the wildcard pattern search block.
// Used by the port checker; no other dependencies.
`ifndef WILDCARD_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_PATTERN_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("wildcard_pattern_search: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("wildcard_pattern_search: assertion failed");

`endif

>>> hdl/wps_pkg.sv
// Shared constants for the wildcard pattern search block.
// No dependencies.
package wps_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;   // pattern_length register
    localparam int LEN_EXT_W = 7;   // holds lengths up to 64
    localparam int PIDX_W    = 5;   // pattern_index field

    // Input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // APB register map
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_ADDR_LSB = 2;
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = LEN_W'(1);

endpackage

>>> hdl/wildcard_pattern_search.sv
// Wildcard pattern search: finds the first occurrence of a loaded pattern in a
// byte stream. Compare unit in wps_window_cmp, constants in wps_pkg.
//
// Usage: load the pattern with opcode 0 requests (one byte and wildcard flag per
// position), set pattern_length over APB (0 acts as 1, values above MAX_PATTERN
// act as MAX_PATTERN), then stream the haystack with opcode 1 requests, one byte
// each, flagging the last one with end_of_data. The first completed match
// returns found=1 with the offset of its first byte; a search that ends without
// a match returns found=0, offset 0. Nothing else returns a response, and
// end_of_data restarts the offset at 0 for the next search. The byte count
// saturates at 2^OFFSET_BITS-1. The block takes one request per clock while
// in_stall is low: window shift, full parallel compare and offset subtract all
// happen in the accept cycle, and the response is registered into the output
// register, or into skid if that is full. This two-entry buffer keeps the
// input open while a response waits; in_stall rises only while both are full.
// Pattern positions must be loaded before a compare uses them; there is no
// clearing of the pattern store after reset.
module wildcard_pattern_search #(
    parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [wps_pkg::PIDX_W-1:0]        pattern_index,
    input  logic [wps_pkg::BYTE_W-1:0]        pattern_byte,
    input  logic                              wildcard_req,
    input  logic [wps_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              end_of_data,
    // response channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [OFFSET_BITS-1:0]            match_offset
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int BW    = wps_pkg::BYTE_W;

    // ---------------------------------------------------------------
    // APB register: pattern_length
    // ---------------------------------------------------------------
    logic [wps_pkg::LEN_W-1:0] len_cfg_reg;
    logic                      reg_sel;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[wps_pkg::APB_ADDR_W-1:wps_pkg::REG_ADDR_LSB]
                      == wps_pkg::REG_PATTERN_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? wps_pkg::APB_DATA_W'(len_cfg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= wps_pkg::PATTERN_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            len_cfg_reg <= pwdata[wps_pkg::LEN_W-1:0];
        end
    end

    // Effective length clamped to 1..MAX_PATTERN
    logic [wps_pkg::LEN_EXT_W-1:0] len_ext;
    logic [wps_pkg::LEN_EXT_W-1:0] len_eff;
    logic [IDX_W-1:0]              len_m1;

    always_comb
    begin
        len_ext = wps_pkg::LEN_EXT_W'(len_cfg_reg);
        if (len_ext == '0)
        begin
            len_eff = wps_pkg::LEN_EXT_W'(1);
        end
        else if (len_ext > wps_pkg::LEN_EXT_W'(MAX_PATTERN))
        begin
            len_eff = wps_pkg::LEN_EXT_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = len_ext;
        end
        len_m1 = IDX_W'(len_eff - wps_pkg::LEN_EXT_W'(1));
    end

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic accept;
    logic take;
    logic load_acc;
    logic data_acc;

    assign accept   = in_valid && !in_stall;
    assign take     = out_valid && !out_stall;
    assign load_acc = accept && (opcode == wps_pkg::OP_LOAD);
    assign data_acc = accept && (opcode == wps_pkg::OP_DATA);

    // ---------------------------------------------------------------
    // Pattern store (no reset; the user must load positions before use)
    // ---------------------------------------------------------------
    logic [BW-1:0]          pattern_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] wild_reg;
    logic [IDX_W-1:0]       load_idx;
    logic                   load_ok;

    assign load_idx = IDX_W'(pattern_index);
    assign load_ok  = (wps_pkg::LEN_EXT_W'(pattern_index) < wps_pkg::LEN_EXT_W'(MAX_PATTERN));

    always_ff @(posedge clk)
    begin
        if (load_acc && load_ok)
        begin
            pattern_reg[load_idx] <= pattern_byte;
            wild_reg[load_idx]    <= wildcard_req;
        end
    end

    // ---------------------------------------------------------------
    // Search state: byte window (entry 0 newest), byte count, match flag
    // ---------------------------------------------------------------
    logic [BW-1:0]          window_reg  [MAX_PATTERN];
    logic [BW-1:0]          window_next [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] seen_reg;
    logic [OFFSET_BITS-1:0] seen_next;
    logic                   match_seen_reg;
    logic                   match_seen_next;
    logic                   seen_sat;
    logic                   enough;
    logic                   hit;
    logic                   new_match;
    logic                   new_miss;
    logic [OFFSET_BITS-1:0] offset_new;

    // Shifted window as it stands after this byte
    always_comb
    begin
        window_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    wps_window_cmp #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W)
    ) u_cmp (
        .window  (window_next),
        .pattern (pattern_reg),
        .wild    (wild_reg),
        .len_m1  (len_m1),
        .hit     (hit)
    );

    // Count after this byte >= len, checked on the old count:
    // saturated count beats any length, else old count + 1 >= len.
    assign seen_sat = &seen_reg;
    assign enough   = seen_sat || (seen_reg >= OFFSET_BITS'(len_m1));

    // Offset = new count - len, with the new count split out by saturation
    assign offset_new = seen_sat ? (seen_reg - OFFSET_BITS'(len_eff))
                                 : (seen_reg - OFFSET_BITS'(len_m1));

    assign new_match = data_acc && !match_seen_reg && enough && hit;
    assign new_miss  = data_acc && !match_seen_reg && !(enough && hit) && end_of_data;

    always_comb
    begin
        seen_next       = seen_reg;
        match_seen_next = match_seen_reg;
        if (data_acc)
        begin
            if (end_of_data)
            begin
                // end of search: back to a fresh search at offset 0
                seen_next       = '0;
                match_seen_next = 1'b0;
            end
            else
            begin
                seen_next       = seen_sat ? seen_reg : seen_reg + OFFSET_BITS'(1);
                match_seen_next = match_seen_reg || new_match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= '0;
            end
            seen_reg       <= '0;
            match_seen_reg <= 1'b0;
        end
        else
        begin
            if (data_acc)
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                begin
                    window_reg[k] <= end_of_data ? '0 : window_next[k];
                end
            end
            seen_reg       <= seen_next;
            match_seen_reg <= match_seen_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid entry
    // ---------------------------------------------------------------
    logic                   res_fire;
    logic [OFFSET_BITS-1:0] res_offset;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic                   out_found_next;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [OFFSET_BITS-1:0] out_offset_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic                   skid_found_reg;
    logic                   skid_found_next;
    logic [OFFSET_BITS-1:0] skid_offset_reg;
    logic [OFFSET_BITS-1:0] skid_offset_next;

    assign res_fire   = new_match || new_miss;
    assign res_offset = new_match ? offset_new : '0;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_found_next   = out_found_reg;
        out_offset_next  = out_offset_reg;
        skid_valid_next  = skid_valid_reg;
        skid_found_next  = skid_found_reg;
        skid_offset_next = skid_offset_reg;
        if (take && skid_valid_reg)
        begin
            // input is stalled while skid is full, so no new response here
            out_found_next  = skid_found_reg;
            out_offset_next = skid_offset_reg;
            skid_valid_next = 1'b0;
        end
        else if (res_fire && out_valid_reg && !take)
        begin
            skid_valid_next  = 1'b1;
            skid_found_next  = new_match;
            skid_offset_next = res_offset;
        end
        else if (res_fire)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = new_match;
            out_offset_next = res_offset;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg   <= out_found_next;
        out_offset_reg  <= out_offset_next;
        skid_found_reg  <= skid_found_next;
        skid_offset_reg <= skid_offset_next;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign match_offset = out_offset_reg;

endmodule

>>> hdl/wps_window_cmp.sv
// Parallel compare of the byte window against the loaded pattern.
// Depends on wps_pkg.
module wps_window_cmp #(
    parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic [wps_pkg::BYTE_W-1:0] window  [MAX_PATTERN],
    input  logic [wps_pkg::BYTE_W-1:0] pattern [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0]     wild,
    input  logic [IDX_W-1:0]           len_m1,
    output logic                       hit
);

    logic [MAX_PATTERN-1:0] miss;

    // Pattern position p lines up with window age len-1-p.
    always_comb
    begin
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            if (IDX_W'(p) <= len_m1)
            begin
                miss[p] = !wild[p] && (pattern[p] != window[len_m1 - IDX_W'(p)]);
            end
            else
            begin
                miss[p] = 1'b0;
            end
        end
    end

    assign hit = ~|miss;

endmodule

>>> hdl/wps_checker.sv
// Port-level checker for wildcard_pattern_search, bound to the top level.
// Depends on wps_pkg and wildcard_pattern_search_assert.svh.
`include "wildcard_pattern_search_assert.svh"

module wps_port_checker #(
    parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pready,
    input  logic                   in_stall,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   found,
    input  logic [OFFSET_BITS-1:0] match_offset
);

    // stalled response holds
    `WPS_ASSERT_NEXT(a_resp_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(match_offset))

    // a miss carries offset zero
    `WPS_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !found, match_offset == '0)

    // input only backs up behind a pending response
    `WPS_ASSERT_NOW(a_stall_needs_resp, clk, rst_n, in_stall, out_valid)

    // APB never inserts wait states
    `WPS_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind wildcard_pattern_search wps_port_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_wps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset)
);

>>> test/wps_checker.sv
`timescale 1ns / 1ps
// Response checker for wildcard_pattern_search: mirrors the pattern store, the
// byte window and the search state, and checks every response. Needs wps_pkg.
module wps_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [wps_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [wps_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  opcode,
    input  logic [wps_pkg::PIDX_W-1:0]            pattern_index,
    input  logic [wps_pkg::BYTE_W-1:0]            pattern_byte,
    input  logic                                  wildcard_req,
    input  logic [wps_pkg::BYTE_W-1:0]            data_byte,
    input  logic                                  end_of_data,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic                                  found,
    input  logic [wps_pkg::OFFSET_BITS_DEF-1:0]   match_offset,
    output int                                    errors,
    output int                                    pending,
    output int                                    hits,
    output int                                    misses
);

    localparam int NPAT = wps_pkg::MAX_PATTERN_DEF;

    typedef struct packed {
        logic                                hit;
        logic [wps_pkg::OFFSET_BITS_DEF-1:0] offset;
    } search_result_t;

    search_result_t                      result_q[$];
    logic [wps_pkg::BYTE_W-1:0]          pat_q[NPAT];
    logic                                wild_q[NPAT];
    logic [wps_pkg::BYTE_W-1:0]          win_q[NPAT];
    logic [wps_pkg::OFFSET_BITS_DEF-1:0] byte_count;
    logic                                match_done;
    logic [wps_pkg::LEN_W-1:0]           len_q;

    // 0 acts as 1, anything above the store depth acts as the depth
    function automatic int active_len();
        if (len_q == '0)
            return 1;
        if (int'(len_q) > NPAT)
            return NPAT;
        return int'(len_q);
    endfunction

    // win_q[0] is the newest byte; pattern position 0 lines up with the oldest
    function automatic bit window_hit(int n);
        for (int p = 0; p < n; p++)
            if (!wild_q[p] && pat_q[p] != win_q[n-1-p])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_search();
        for (int i = 0; i < NPAT; i++)
            win_q[i] = '0;
        byte_count = '0;
        match_done = 1'b0;
    endtask

    task automatic scan_byte(logic [wps_pkg::BYTE_W-1:0] b, logic last);
        int             n;
        search_result_t r;
        n = active_len();
        for (int i = NPAT - 1; i > 0; i--)
            win_q[i] = win_q[i-1];
        win_q[0] = b;
        if (byte_count != '1)
            byte_count++;
        if (!match_done && byte_count >= n && window_hit(n))
        begin
            match_done = 1'b1;
            r.hit      = 1'b1;
            r.offset   = byte_count - wps_pkg::OFFSET_BITS_DEF'(n);
            result_q.push_back(r);
        end
        else if (last && !match_done)
        begin
            r.hit    = 1'b0;
            r.offset = '0;
            result_q.push_back(r);
        end
        if (last)
            clear_search();
    endtask

    // Everything is driven at the rising edge, so the falling edge sees stable
    // values for the transfer about to happen.
    always @(negedge clk)
    begin : watch
        search_result_t want;
        if (!rst_n)
        begin
            clear_search();
            len_q = wps_pkg::PATTERN_LENGTH_RST;
            result_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[wps_pkg::APB_ADDR_W-1:wps_pkg::REG_ADDR_LSB]
                   == wps_pkg::REG_PATTERN_LENGTH)
                len_q = pwdata[wps_pkg::LEN_W-1:0];

            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected response found=%0d offset=%0d",
                                 $realtime, found, match_offset);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (found !== want.hit || match_offset !== want.offset)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: expected found=%0d offset=%0d, ",
                                      "got found=%0d offset=%0d"},
                                     $realtime, want.hit, want.offset, found,
                                     match_offset);
                    end
                    else if (want.hit)
                        hits++;
                    else
                        misses++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (opcode == wps_pkg::OP_LOAD)
                begin
                    if (int'(pattern_index) < NPAT)
                    begin
                        pat_q[pattern_index]  = pattern_byte;
                        wild_q[pattern_index] = wildcard_req;
                    end
                end
                else
                    scan_byte(data_byte, end_of_data);
            end
        end
        pending = result_q.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for wildcard_pattern_search: clock, reset, APB length
// setup and request traffic. Needs wps_pkg, the RTL and wps_checker.
module tb;

    localparam int NPAT        = wps_pkg::MAX_PATTERN_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 730;
    // cycles to let the block settle before a register write; the response
    // is registered in the cycle after the request, plus the skid entry
    localparam int SETTLE      = 4;

    logic                                clk;
    logic                                rst_n         = 1'b0;
    logic                                psel          = 1'b0;
    logic                                penable       = 1'b0;
    logic                                pwrite        = 1'b0;
    logic [wps_pkg::APB_ADDR_W-1:0]      paddr         = '0;
    logic [wps_pkg::APB_DATA_W-1:0]      pwdata        = '0;
    logic [wps_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;
    logic                                in_valid      = 1'b0;
    logic                                in_stall;
    logic                                opcode        = wps_pkg::OP_LOAD;
    logic [wps_pkg::PIDX_W-1:0]          pattern_index = '0;
    logic [wps_pkg::BYTE_W-1:0]          pattern_byte  = '0;
    logic                                wildcard_req  = 1'b0;
    logic [wps_pkg::BYTE_W-1:0]          data_byte     = '0;
    logic                                end_of_data   = 1'b0;
    logic                                out_valid;
    logic                                out_stall     = 1'b0;
    logic                                found;
    logic [wps_pkg::OFFSET_BITS_DEF-1:0] match_offset;

    int errors, pending, hits, misses;

    // traffic shaping: gap/stall percentages change per phase; quiet turns
    // all idling off for the tail of the run
    int gap_pct   = 0;
    int stall_pct = 0;
    bit quiet     = 1'b0;
    int quiet_from = 1 << 30;
    int loads_sent, bytes_sent, settings_used;
    int watch_cycles;

    // image of the pattern as loaded, used to plant matches in the haystack
    logic [wps_pkg::BYTE_W-1:0] pat_img[NPAT];
    bit                         wild_img[NPAT];

    wildcard_pattern_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pattern_index (pattern_index),
        .pattern_byte  (pattern_byte),
        .wildcard_req  (wildcard_req),
        .data_byte     (data_byte),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_offset  (match_offset)
    );

    wps_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pattern_index (pattern_index),
        .pattern_byte  (pattern_byte),
        .wildcard_req  (wildcard_req),
        .data_byte     (data_byte),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_offset  (match_offset),
        .errors        (errors),
        .pending       (pending),
        .hits          (hits),
        .misses        (misses)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
            @(posedge clk);
        $display("[wildcard_pattern_search] ERROR");
        $finish;
    end

    // Response side back-pressure: random bursts of stall.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Mostly a small alphabet so that partial and full matches happen often;
    // the extremes and a share of arbitrary bytes keep every bit moving.
    function automatic logic [wps_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return wps_pkg::BYTE_W'($urandom);
            default: return 8'h40 + wps_pkg::BYTE_W'($urandom_range(2));
        endcase
    endfunction

    function automatic int eff_len(int v);
        if (v == 0)
            return 1;
        if (v > NPAT)
            return NPAT;
        return v;
    endfunction

    // One request. An optional idle burst goes first; then the payload is
    // held until a rising edge sees it with stall low. Stall is sampled at
    // the falling edge, where everything has settled.
    task automatic send_req(logic op, logic [wps_pkg::PIDX_W-1:0] idx,
                            logic [wps_pkg::BYTE_W-1:0] pb, logic wc,
                            logic [wps_pkg::BYTE_W-1:0] db, logic last);
        bit stalled;
        if (loads_sent + bytes_sent >= quiet_from)
            quiet = 1'b1;
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        pattern_index <= idx;
        pattern_byte  <= pb;
        wildcard_req  <= wc;
        data_byte     <= db;
        end_of_data   <= last;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        if (op == wps_pkg::OP_LOAD)
            loads_sent++;
        else
            bytes_sent++;
    endtask

    // Unused fields of each request carry noise; the block must ignore them.
    task automatic load_entry(int idx, logic [wps_pkg::BYTE_W-1:0] pb, logic wc);
        if (idx < NPAT)
        begin
            pat_img[idx]  = pb;
            wild_img[idx] = wc;
        end
        send_req(wps_pkg::OP_LOAD, wps_pkg::PIDX_W'(idx), pb, wc,
                 wps_pkg::BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic scan(logic [wps_pkg::BYTE_W-1:0] db, logic last);
        send_req(wps_pkg::OP_DATA, wps_pkg::PIDX_W'($urandom),
                 wps_pkg::BYTE_W'($urandom), 1'($urandom), db, last);
    endtask

    // Register writes only with the block idle: nothing outstanding, and a
    // few more cycles for a request that produced no response.
    task automatic set_length(int unsigned value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wps_pkg::APB_ADDR_W'(wps_pkg::REG_PATTERN_LENGTH)
                   << wps_pkg::REG_ADDR_LSB;
        pwdata  <= wps_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic load_pattern(int n);
        for (int i = 0; i < n; i++)
            load_entry(i, pick_byte(), $urandom_range(4) == 0);
    endtask

    // One search, always closed with end_of_data. Most plant the pattern at a
    // random spot; some plant a damaged copy, some are pure noise, and a few
    // end before a full window. A rare pattern rewrite lands mid-search.
    task automatic run_search(int n);
        int                         total;
        int                         at;
        int                         mode;
        int                         broken;
        logic [wps_pkg::BYTE_W-1:0] b;
        if ($urandom_range(5) == 0)
            total = $urandom_range(1, n);
        else
            total = $urandom_range(n, (n > 8) ? n + 8 : 2 * n + 12);
        mode   = $urandom_range(9);
        at     = (mode < 8 && total >= n) ? $urandom_range(0, total - n) : -1;
        broken = (mode >= 6) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < total; i++)
        begin
            if (at >= 0 && i >= at && i < at + n)
            begin
                b = wild_img[i-at] ? wps_pkg::BYTE_W'($urandom) : pat_img[i-at];
                if (i - at == broken)
                    b = b ^ 8'h80;
            end
            else
                b = pick_byte();
            if ($urandom_range(49) == 0)
                load_entry($urandom_range(0, NPAT - 1), pick_byte(), 1'($urandom));
            scan(b, i == total - 1);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int v;
        int n;
        int rand_goal;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part; the length register starts at 1 ---
        load_entry(0, 8'hFF, 1'b0);
        scan(8'h00, 1'b0);
        scan(8'hFF, 1'b0);      // first match, offset 1
        scan(8'hFF, 1'b1);      // end of search after a match: silent
        scan(8'hFF, 1'b1);      // match on the closing byte only
        scan(8'h00, 1'b1);      // search ends without a match

        set_length(3);
        load_entry(0, 8'h00, 1'b0);
        load_entry(1, 8'hAB, 1'b1);
        load_entry(2, 8'hFF, 1'b0);
        scan(8'h00, 1'b0);
        scan(8'h11, 1'b1);      // stream shorter than the pattern
        scan(8'hFF, 1'b0);
        scan(8'h00, 1'b0);
        scan(8'h5A, 1'b0);
        scan(8'hFF, 1'b0);      // wildcard in the middle, match at offset 1
        scan(8'h00, 1'b1);
        scan(8'h00, 1'b0);
        load_entry(2, 8'h5A, 1'b0);  // pattern change inside a search
        scan(8'h77, 1'b0);
        scan(8'h5A, 1'b1);

        // --- random part: phases of length setting, pattern load, searches ---
        rand_goal  = loads_sent + bytes_sent + RANDOM_REQS;
        quiet_from = rand_goal - 100;
        phase      = 0;
        while (loads_sent + bytes_sent < rand_goal)
        begin
            case (phase)
                0:       v = 63;     // above the store depth
                1:       v = 0;      // acts as 1
                2:       v = NPAT;
                3:       v = 1;
                default: v = ($urandom_range(3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(1, 6);
            endcase
            gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
            set_length(v);
            n = eff_len(v);
            load_pattern(n);
            repeat ((n > 8) ? 1 : $urandom_range(2, 6))
                run_search(n);
            phase++;
        end

        // --- drain ---
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d requests: %0d pattern loads, %0d haystack bytes",
                 loads_sent + bytes_sent, loads_sent, bytes_sent);
        $display("Used %0d length writes; checked %0d searches with a match and %0d without",
                 settings_used, hits, misses);
        if (errors == 0 && pending == 0)
            $display("[wildcard_pattern_search] OK");
        else
            $display("[wildcard_pattern_search] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/wps_pkg.sv
hdl/wps_window_cmp.sv
hdl/wildcard_pattern_search.sv
hdl/wps_checker.sv
test/wps_checker.sv
test/tb.sv
